FILE: sv/entity_lump_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// Entity lump tokenizer assertion macros
// Shorthand for clocked checks that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ENTITY_LUMP_TOKENIZER_CORE_ASSERT_SVH
`define ENTITY_LUMP_TOKENIZER_CORE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define ELT_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that forces another one at the next clock edge.
`define ELT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/elt_pkg.sv
// ----------------------------------------------------------------------------
// Entity lump tokenizer package
// Word types, event and state encodings and character codes shared by the
// tokenizer step logic and the top level.
// ----------------------------------------------------------------------------
package elt_pkg;

    // Most events that one input word can cause.
    localparam int MaxEvents = 5;
    localparam int EvCntW    = $clog2(MaxEvents + 1);

    // Event kinds.
    localparam logic [2:0] EV_CHAR         = 3'd0;
    localparam logic [2:0] EV_TOKEN_END    = 3'd1;
    localparam logic [2:0] EV_ENTITY_BEGIN = 3'd2;
    localparam logic [2:0] EV_ENTITY_END   = 3'd3;
    localparam logic [2:0] EV_STOP         = 3'd4;

    // Roles.
    localparam logic ROLE_KEY   = 1'b0;
    localparam logic ROLE_VALUE = 1'b1;

    // Scanner modes.
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_QUOTED  = 3'd2;
    localparam logic [2:0] MODE_BARE    = 3'd3;
    localparam logic [2:0] MODE_STOPPED = 3'd4;

    // Nesting levels.
    localparam logic [1:0] LVL_OUTSIDE = 2'd0;
    localparam logic [1:0] LVL_KEY     = 2'd1;
    localparam logic [1:0] LVL_VALUE   = 2'd2;

    // Request types.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } elt_in_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic       role;
        logic [7:0] out_char;
        logic       last;
    } elt_out_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       role;
        logic [7:0] ch;
    } elt_ev_t;

    typedef elt_ev_t [MaxEvents-1:0] elt_ev_arr_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] level;
        logic       held_valid;
        logic [1:0] token_count;
        logic [7:0] first_char;
        logic       hash_seen;
    } elt_state_t;

endpackage

FILE: sv/entity_lump_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Entity lump tokenizer core
// Streams the text of a key-value entity block and emits key and value
// characters, token ends, entity begin and end, and a stop event.
// ----------------------------------------------------------------------------
// The core takes one input word per cycle unless stalled. All events that a
// word causes are computed in the same cycle and loaded into a five-entry
// event buffer, which drains one result word per cycle while result_ready is
// high; a new input word is taken once the buffer is empty, or holds only its
// last event and that event is leaving, so plain text runs at one byte per
// clock while result_ready is high. After reset the scanner is between tokens,
// outside any entity. An end-of-data word flushes the open token and entity,
// reports a stop unless stopped already, returns the scanner to its reset state.
module entity_lump_tokenizer_core
    import elt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  elt_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output elt_out_t result
);

`include "entity_lump_tokenizer_core_assert.svh"

    elt_state_t        state_reg;
    elt_state_t        state_next;
    elt_ev_arr_t       ev_reg;
    elt_ev_arr_t       ev_new;
    logic [EvCntW-1:0] cnt_reg;
    logic [EvCntW-1:0] cnt_new;
    logic              in_acc;
    logic              out_acc;

    elt_step u_step (
        .cur_state  (state_reg),
        .item       (item),
        .next_state (state_next),
        .events     (ev_new),
        .ev_cnt     (cnt_new)
    );

    assign result_valid = (cnt_reg != '0);
    assign out_acc      = result_valid && result_ready;
    assign item_ready   = (cnt_reg == '0) || ((cnt_reg == EvCntW'(1)) && result_ready);
    assign in_acc       = item_valid && item_ready;

    assign result.event_kind = ev_reg[0].kind;
    assign result.role       = ev_reg[0].role;
    assign result.out_char   = ev_reg[0].ch;
    assign result.last       = (cnt_reg == EvCntW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_new;
        end
        else if (out_acc)
        begin
            cnt_reg <= cnt_reg - EvCntW'(1);
        end
    end

    // The head of the buffer is always the next result word.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ev_reg <= ev_new;
        end
        else if (out_acc)
        begin
            for (int i = 0; i < MaxEvents - 1; i++)
            begin
                ev_reg[i] <= ev_reg[i + 1];
            end
        end
    end

    `ELT_CHECK(a_cnt_range, cnt_reg <= EvCntW'(MaxEvents), "event count beyond buffer depth")
    `ELT_CHECK(a_no_overwrite, !in_acc || cnt_reg == '0 || out_acc,
               "input taken while events still pending")
    `ELT_CHECK_NEXT(a_events_shown, in_acc && cnt_new != '0, result_valid,
                    "events of an accepted word not presented")
    `ELT_CHECK(a_stop_outside, state_reg.mode != MODE_STOPPED || state_reg.level == LVL_OUTSIDE,
               "stopped scanner inside an entity")
    `ELT_CHECK(a_mode_legal, state_reg.mode <= MODE_STOPPED, "scanner mode out of range")

endmodule

FILE: sv/elt_step.sv
// ----------------------------------------------------------------------------
// Entity lump tokenizer step
// Combinational update for one input word: next scanner state and the list
// of events that the word causes, in order.
// ----------------------------------------------------------------------------
module elt_step
    import elt_pkg::*;
(
    input  elt_state_t  cur_state,
    input  elt_in_t     item,
    output elt_state_t  next_state,
    output elt_ev_arr_t events,
    output logic [EvCntW-1:0] ev_cnt
);

    typedef struct packed {
        elt_state_t        st;
        elt_ev_arr_t       ev;
        logic [EvCntW-1:0] n;
    } ctx_t;

    function automatic ctx_t emit(ctx_t c, logic [2:0] kind, logic role, logic [7:0] ch);
        if (c.n < EvCntW'(MaxEvents))
        begin
            c.ev[c.n] = '{kind: kind, role: role, ch: ch};
            c.n       = c.n + EvCntW'(1);
        end
        return c;
    endfunction

    function automatic logic is_single(logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
               (b == CH_RPAREN) || (b == CH_APOS);
    endfunction

    function automatic ctx_t tok_begin(ctx_t c);
        c.st.token_count = 2'd0;
        c.st.first_char  = 8'd0;
        c.st.hash_seen   = 1'b0;
        return c;
    endfunction

    function automatic ctx_t key_byte(ctx_t c, logic [7:0] b);
        if (b == CH_HASH)
        begin
            c.st.hash_seen = 1'b1;
        end
        if (!c.st.hash_seen)
        begin
            c = emit(c, EV_CHAR, ROLE_KEY, b);
        end
        return c;
    endfunction

    // The first key byte is held back so that a lone closing brace never
    // shows up as key text.
    function automatic ctx_t tok_char(ctx_t c, logic [7:0] b);
        if (c.st.level == LVL_VALUE)
        begin
            c = emit(c, EV_CHAR, ROLE_VALUE, b);
        end
        else if (c.st.level == LVL_KEY)
        begin
            if (c.st.token_count == 2'd0)
            begin
                c.st.first_char = b;
                if (b == CH_HASH)
                begin
                    c.st.hash_seen = 1'b1;
                end
            end
            else
            begin
                if (c.st.token_count == 2'd1 && c.st.first_char != CH_HASH)
                begin
                    c = emit(c, EV_CHAR, ROLE_KEY, c.st.first_char);
                end
                c = key_byte(c, b);
            end
        end
        else if (c.st.token_count == 2'd0)
        begin
            c.st.first_char = b;
        end
        if (c.st.token_count < 2'd2)
        begin
            c.st.token_count = c.st.token_count + 2'd1;
        end
        return c;
    endfunction

    function automatic ctx_t tok_end(ctx_t c);
        c.st.mode = MODE_BETWEEN;
        if (c.st.level == LVL_OUTSIDE)
        begin
            if (c.st.token_count == 2'd0)
            begin
                c         = emit(c, EV_STOP, ROLE_KEY, 8'd0);
                c.st.mode = MODE_STOPPED;
            end
            else if (c.st.token_count == 2'd1 && c.st.first_char == CH_LBRACE)
            begin
                c          = emit(c, EV_ENTITY_BEGIN, ROLE_KEY, 8'd0);
                c.st.level = LVL_KEY;
            end
        end
        else if (c.st.level == LVL_KEY)
        begin
            if (c.st.token_count == 2'd0 ||
                (c.st.token_count == 2'd1 && c.st.first_char == CH_RBRACE))
            begin
                c          = emit(c, EV_ENTITY_END, ROLE_KEY, 8'd0);
                c.st.level = LVL_OUTSIDE;
            end
            else
            begin
                if (c.st.token_count == 2'd1 && c.st.first_char != CH_HASH)
                begin
                    c = emit(c, EV_CHAR, ROLE_KEY, c.st.first_char);
                end
                c          = emit(c, EV_TOKEN_END, ROLE_KEY, 8'd0);
                c.st.level = LVL_VALUE;
            end
        end
        else
        begin
            c          = emit(c, EV_TOKEN_END, ROLE_VALUE, 8'd0);
            c.st.level = LVL_KEY;
        end
        c = tok_begin(c);
        return c;
    endfunction

    function automatic ctx_t start_at(ctx_t c, logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            c         = tok_begin(c);
            c.st.mode = MODE_QUOTED;
        end
        else if (is_single(b))
        begin
            c = tok_begin(c);
            c = tok_char(c, b);
            c = tok_end(c);
        end
        else if (b == CH_SLASH)
        begin
            c.st.held_valid = 1'b1;
        end
        else
        begin
            c         = tok_begin(c);
            c.st.mode = MODE_BARE;
            c         = tok_char(c, b);
        end
        return c;
    endfunction

    function automatic ctx_t bare_byte(ctx_t c, logic [7:0] b);
        if (b <= CH_SPACE)
        begin
            c = tok_end(c);
        end
        else if (is_single(b))
        begin
            c = tok_end(c);
            if (c.st.mode == MODE_BETWEEN)
            begin
                c = start_at(c, b);
            end
        end
        else
        begin
            c = tok_char(c, b);
        end
        return c;
    endfunction

    ctx_t ctx;

    always_comb
    begin
        ctx    = '0;
        ctx.st = cur_state;
        if (item.req_type == REQ_DATA)
        begin
            unique case (ctx.st.mode)
                MODE_COMMENT:
                begin
                    if (item.in_byte == CH_NL)
                    begin
                        ctx.st.mode = MODE_BETWEEN;
                    end
                end
                MODE_QUOTED:
                begin
                    if (item.in_byte == CH_QUOTE)
                    begin
                        ctx = tok_end(ctx);
                    end
                    else
                    begin
                        ctx = tok_char(ctx, item.in_byte);
                    end
                end
                MODE_BARE:
                begin
                    ctx = bare_byte(ctx, item.in_byte);
                end
                MODE_BETWEEN:
                begin
                    // A held slash either opens a comment or starts a bare word.
                    if (ctx.st.held_valid)
                    begin
                        ctx.st.held_valid = 1'b0;
                        if (item.in_byte == CH_SLASH)
                        begin
                            ctx.st.mode = MODE_COMMENT;
                        end
                        else
                        begin
                            ctx         = tok_begin(ctx);
                            ctx.st.mode = MODE_BARE;
                            ctx         = tok_char(ctx, CH_SLASH);
                            ctx         = bare_byte(ctx, item.in_byte);
                        end
                    end
                    else if (item.in_byte > CH_SPACE)
                    begin
                        ctx = start_at(ctx, item.in_byte);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (ctx.st.mode != MODE_STOPPED)
            begin
                if (ctx.st.held_valid)
                begin
                    ctx.st.held_valid = 1'b0;
                    ctx               = tok_begin(ctx);
                    ctx               = tok_char(ctx, CH_SLASH);
                    ctx               = tok_end(ctx);
                end
                else if (ctx.st.mode == MODE_QUOTED || ctx.st.mode == MODE_BARE)
                begin
                    ctx = tok_end(ctx);
                end
                if (ctx.st.mode != MODE_STOPPED)
                begin
                    if (ctx.st.level == LVL_VALUE)
                    begin
                        ctx          = emit(ctx, EV_TOKEN_END, ROLE_VALUE, 8'd0);
                        ctx.st.level = LVL_KEY;
                    end
                    if (ctx.st.level == LVL_KEY)
                    begin
                        ctx = emit(ctx, EV_ENTITY_END, ROLE_KEY, 8'd0);
                    end
                    ctx = emit(ctx, EV_STOP, ROLE_KEY, 8'd0);
                end
            end
            ctx.st = '0;
        end
    end

    assign next_state = ctx.st;
    assign events     = ctx.ev;
    assign ev_cnt     = ctx.n;

endmodule
